// ----- design/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared sizes, codes and link types of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int DEPTH      = 16;
   localparam int DELAY_BITS = 16;
   localparam int EVENT_BITS = 8;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   typedef logic [DELAY_BITS-1:0] delay_type;
   typedef logic [EVENT_BITS-1:0] evt_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ZERO     = 2'd2,
      STATUS_FIRED    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_WALK   = 3'd1,
      OP_INSERT = 3'd2,
      OP_SHIFT  = 3'd3,
      OP_DEC    = 3'd4
   } cell_op_type;

   // toward the tail: walk token, remaining delay, entry for a right shift
   typedef struct packed {
      logic      tok;
      delay_type rem;
      delay_type delta;
      evt_type   evt;
   } fwd_link_type;

   // toward the head: entry for a left shift
   typedef struct packed {
      delay_type delta;
      evt_type   evt;
   } back_link_type;

   typedef struct packed {
      cell_op_type op;
      evt_type     evt;
   } cell_ctrl_type;

   typedef struct packed {
      logic    head_fire;
      logic    next_fire;
      evt_type head_evt;
   } chain_stat_type;

endpackage

// ----- design/dtq_req_if.sv -----
// ----------------------------------------------------------------------------
// dtq_req_if
// Request channel: insert or tick command with delay and event id.
// ----------------------------------------------------------------------------
interface dtq_req_if import dtq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [DELAY_BITS-1:0] delay;
   logic [EVENT_BITS-1:0] event_id;

   modport source (output valid, output cmd, output delay, output event_id, input ready);
   modport sink   (input valid, input cmd, input delay, input event_id, output ready);
endinterface

// ----- design/dtq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dtq_rsp_if
// Response channel: status, fired event id and last marker.
// ----------------------------------------------------------------------------
interface dtq_rsp_if import dtq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [EVENT_BITS-1:0] fired_event;
   logic                  last;

   modport source (output valid, output status, output fired_event, output last, input ready);
   modport sink   (input valid, input status, input fired_event, input last, output ready);
endinterface

// ----- design/dtq_cell.sv -----
// ----------------------------------------------------------------------------
// dtq_cell
// One queue slot: relative delay, event id and the walk token of an insert.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head,
   input  logic          occ,
   input  cell_ctrl_type ctrl,
   input  fwd_link_type  fwd_in,
   input  back_link_type back_in,
   output fwd_link_type  fwd_out,
   output back_link_type back_out,
   output logic          hit
);

   delay_type delta_ff, delta_in;
   evt_type   evt_ff, evt_in;
   delay_type rem_ff, rem_in;
   logic      tok_ff, tok_in;
   logic      passed_ff, passed_in;
   logic      hit_ff, hit_in;
   logic      fits;

   assign fits = occ && (rem_ff >= delta_ff);

   always_comb begin
      fwd_out.tok   = tok_ff && fits;
      fwd_out.rem   = rem_ff - delta_ff;
      fwd_out.delta = hit_ff ? (delta_ff - rem_ff) : delta_ff;
      fwd_out.evt   = evt_ff;
      back_out.delta = delta_ff;
      back_out.evt   = evt_ff;
   end

   assign hit = hit_ff;

   always_comb begin
      delta_in  = delta_ff;
      evt_in    = evt_ff;
      rem_in    = rem_ff;
      tok_in    = tok_ff;
      passed_in = passed_ff;
      hit_in    = hit_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_WALK: begin
            // take the token from the left, pass it on or stop here
            tok_in = fwd_in.tok;
            if (fwd_in.tok) begin
               rem_in = fwd_in.rem;
            end
            if (tok_ff) begin
               if (fits) begin
                  passed_in = 1'b1;
               end else begin
                  hit_in = 1'b1;
               end
            end
         end
         OP_INSERT: begin
            if (hit_ff) begin
               delta_in = rem_ff;
               evt_in   = ctrl.evt;
            end else if (!passed_ff) begin
               delta_in = fwd_in.delta;
               evt_in   = fwd_in.evt;
            end
            tok_in    = 1'b0;
            passed_in = 1'b0;
            hit_in    = 1'b0;
         end
         OP_SHIFT: begin
            delta_in = back_in.delta;
            evt_in   = back_in.evt;
         end
         OP_DEC: begin
            if (head && (delta_ff != '0)) begin
               delta_in = delta_ff - delay_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      evt_ff   <= evt_in;
      rem_ff   <= rem_in;
      if (reset) begin
         tok_ff    <= 1'b0;
         passed_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         tok_ff    <= tok_in;
         passed_ff <= passed_in;
         hit_ff    <= hit_in;
      end
   end

endmodule

// ----- design/dtq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: accepts commands, steers the cell chain, owns the entry count
// and the response register.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dtq_req_if.sink            req,
   dtq_rsp_if.source          rsp,
   input  chain_stat_type     stat,
   input  logic [DEPTH-1:0]   hit_vec,
   output cell_ctrl_type      ctrl,
   output fwd_link_type       head_link,
   output count_type          count
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_FIRE  = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   evt_type    evt_ff, evt_in;
   status_type pend_ff, pend_in;
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   evt_type    out_evt_ff, out_evt_in;
   logic       out_last_ff, out_last_in;
   logic       slot_free;
   logic       accept;
   logic       any_hit;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign any_hit   = |hit_vec;
   assign count     = count_ff;

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.fired_event = out_evt_ff;
   assign rsp.last        = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      evt_in        = evt_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_status_in = out_status_ff;
      out_evt_in    = out_evt_ff;
      out_last_in   = out_last_ff;
      ctrl.op       = OP_HOLD;
      ctrl.evt      = evt_ff;
      head_link     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cmd_type'(req.cmd) == CMD_INSERT) begin
                  if (req.delay == '0) begin
                     pend_in  = STATUS_ZERO;
                     state_in = ST_REPLY;
                  end else if (count_ff == count_type'(DEPTH)) begin
                     pend_in  = STATUS_FULL;
                     state_in = ST_REPLY;
                  end else begin
                     // launch the walk token at the head
                     ctrl.op       = OP_WALK;
                     head_link.tok = 1'b1;
                     head_link.rem = req.delay;
                     evt_in        = req.event_id;
                     state_in      = ST_WALK;
                  end
               end else if (count_ff != '0) begin
                  ctrl.op  = OP_DEC;
                  state_in = ST_FIRE;
               end
            end
         end
         ST_WALK: begin
            if (any_hit) begin
               ctrl.op  = OP_INSERT;
               count_in = count_ff + count_type'(1);
               pend_in  = STATUS_INSERTED;
               state_in = ST_REPLY;
            end else begin
               ctrl.op = OP_WALK;
            end
         end
         ST_FIRE: begin
            if (!stat.head_fire) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               // report the head and drop it
               out_valid_in  = 1'b1;
               out_status_in = STATUS_FIRED;
               out_evt_in    = stat.head_evt;
               out_last_in   = !stat.next_fire;
               ctrl.op       = OP_SHIFT;
               count_in      = count_ff - count_type'(1);
               if (!stat.next_fire) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = pend_ff;
               out_evt_in    = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      evt_ff        <= evt_in;
      pend_ff       <= pend_in;
      out_status_ff <= out_status_in;
      out_evt_ff    <= out_evt_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count beyond depth");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one insert point");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && any_hit |=> count_ff == $past(count_ff) + count_type'(1))
      else $error("insert did not grow the queue");

   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_INSERT) && (req.delay != '0)
      && (count_ff != count_type'(DEPTH)) |=> state_ff == ST_WALK)
      else $error("insert did not start a walk");

endmodule

// ----- design/delta_timer_queue_top.sv -----
// ----------------------------------------------------------------------------
// delta_timer_queue_top
// Delta-encoded timer queue built as a chain of entry cells.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    cmd, delay, event_id
//   rsp      out  valid / ready    status, fired_event, last
//
// Insert: the walk token moves one cell per cycle until it stops at the insert
//   point; then the entry is placed and the reply is registered.
// Tick: the head is decremented, then each expired entry is reported and dropped.
// Reset is synchronous and empties the queue; cell contents are not cleared.
// A response waits in the output register; the sequencer holds while it is
//   occupied and not taken.
// ----------------------------------------------------------------------------
module delta_timer_queue_top import dtq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dtq_req_if.sink   req,
   dtq_rsp_if.source rsp
);

   cell_ctrl_type    ctrl;
   fwd_link_type     head_link;
   count_type        count;
   chain_stat_type   stat;
   logic [DEPTH-1:0] hit_vec;
   logic [DEPTH-1:0] occ;
   fwd_link_type     fwd [DEPTH+1];
   back_link_type    back [DEPTH+1];

   assign fwd[0]      = head_link;
   assign back[DEPTH] = '0;

   always_comb begin
      stat.head_fire = occ[0] && (back[0].delta == '0);
      stat.next_fire = occ[1] && (back[1].delta == '0);
      stat.head_evt  = back[0].evt;
   end

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .stat      (stat),
      .hit_vec   (hit_vec),
      .ctrl      (ctrl),
      .head_link (head_link),
      .count     (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i] = (count > count_type'(i));

      dtq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .head     (i == 0),
         .occ      (occ[i]),
         .ctrl     (ctrl),
         .fwd_in   (fwd[i]),
         .back_in  (back[i+1]),
         .fwd_out  (fwd[i+1]),
         .back_out (back[i]),
         .hit      (hit_vec[i])
      );
   end

endmodule

// ----- tb/dtq_timer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtq_timer_checker
// Watches both channels of the delta timer queue. Each accepted request
// advances a private copy of the timer list and queues the status and expiry
// results it must produce. Each response transfer is compared field by field
// with the oldest queued result. Reports the failure count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module dtq_timer_checker import dtq_pkg::*; (
   input  logic clock,
   input  logic reset,
   dtq_req_if   req_mon,
   dtq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   expected_left
);

   typedef struct packed {
      status_type status;
      evt_type    fired;
      logic       last;
   } timer_result_type;

   delay_type        slot_delta [DEPTH];
   evt_type          slot_evt   [DEPTH];
   int               slot_used = 0;
   timer_result_type expected_results [$];
   int               fails = 0;

   function automatic timer_result_type make_result(status_type st, evt_type ev, logic lst);
      timer_result_type r;
      r.status = st;
      r.fired  = ev;
      r.last   = lst;
      return r;
   endfunction

   task automatic predict_insert(delay_type dly, evt_type ev);
      delay_type rem;
      int        pos;
      int        k;
      rem = dly;
      pos = 0;
      if (dly == '0) begin
         expected_results.push_back(make_result(STATUS_ZERO, '0, 1'b1));
      end else if (slot_used >= DEPTH) begin
         expected_results.push_back(make_result(STATUS_FULL, '0, 1'b1));
      end else begin
         while (pos < slot_used && rem >= slot_delta[pos]) begin
            rem = rem - slot_delta[pos];
            pos++;
         end
         for (k = slot_used; k > pos; k--) begin
            slot_delta[k] = slot_delta[k-1];
            slot_evt[k]   = slot_evt[k-1];
         end
         slot_delta[pos] = rem;
         slot_evt[pos]   = ev;
         slot_used++;
         if (pos + 1 < slot_used) begin
            slot_delta[pos+1] = slot_delta[pos+1] - rem;
         end
         expected_results.push_back(make_result(STATUS_INSERTED, '0, 1'b1));
      end
   endtask

   task automatic predict_tick();
      evt_type expired [DEPTH];
      int      n;
      int      k;
      n = 0;
      if (slot_used == 0) return;
      if (slot_delta[0] != '0) slot_delta[0] = slot_delta[0] - delay_type'(1);
      while (slot_used > 0 && slot_delta[0] == '0 && n < DEPTH) begin
         expired[n] = slot_evt[0];
         n++;
         for (k = 1; k < slot_used; k++) begin
            slot_delta[k-1] = slot_delta[k];
            slot_evt[k-1]   = slot_evt[k];
         end
         slot_used--;
      end
      for (k = 0; k < n; k++) begin
         expected_results.push_back(make_result(STATUS_FIRED, expired[k], k == n - 1));
      end
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         slot_used = 0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0d fired_event %0d last %0d",
                      rsp_mon.status, rsp_mon.fired_event, rsp_mon.last);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  fails++;
               end
               if (rsp_mon.fired_event !== want.fired) begin
                  $error("fired_event mismatch: expected %0d, actual %0d",
                         want.fired, rsp_mon.fired_event);
                  fails++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d",
                         want.last, rsp_mon.last);
                  fails++;
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.cmd == CMD_TICK) begin
               predict_tick();
            end else begin
               predict_insert(req_mon.delay, req_mon.event_id);
            end
         end
      end
      fail_count    <= fails;
      expected_left <= expected_results.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the delta timer queue. A directed opening covers a tick on an
// empty queue, zero and maximum delays, equal expiries, a full queue and
// multi-entry expiries; then phases of random inserts and ticks follow with
// bursty idling on both channels and one long response hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import dtq_pkg::*;

   localparam int ITEM_TOTAL    = 450;
   localparam int QUIET_FROM    = 400;
   localparam int SQUEEZE_AT    = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = DEPTH + 24;
   localparam int STALL_LIMIT   = 4000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   expected_left;
   int   items_sent  = 0;
   int   idle_cycles = 0;
   bit   quiet_tail  = 1'b0;
   bit   squeeze_now = 1'b0;

   dtq_req_if req ();
   dtq_rsp_if rsp ();

   delta_timer_queue_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   dtq_timer_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req),
      .rsp_mon       (rsp),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_item(cmd_type op, delay_type dly, evt_type ev);
      req.valid    <= 1'b1;
      req.cmd      <= op;
      req.delay    <= dly;
      req.event_id <= ev;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (items_sent >= QUIET_FROM) quiet_tail = 1'b1;
      if (items_sent == SQUEEZE_AT) squeeze_now = 1'b1;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   initial begin
      delay_type seed_delays [15];
      int        insert_pct;
      int        roll;
      int        k;
      delay_type dly;

      seed_delays = '{16'd3, 16'd1, 16'd3, 16'd5, 16'd3, 16'd2, 16'd1,
                      16'd7, 16'd2, 16'd12, 16'd3, 16'd1, 16'd6,
                      16'd9, 16'd4};
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.cmd      <= CMD_TICK;
      req.delay    <= '0;
      req.event_id <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_TICK, '0, '0);
      send_item(CMD_INSERT, '0, '1);
      send_item(CMD_INSERT, '1, '1);
      for (k = 0; k < 15; k++) begin
         send_item(CMD_INSERT, seed_delays[k], evt_type'(k * 17));
      end
      send_item(CMD_INSERT, 16'd1, 8'h5A);
      send_item(CMD_INSERT, '0, 8'hA5);
      repeat (4) send_item(CMD_TICK, '1, '1);

      while (items_sent < ITEM_TOTAL) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 25;
            1:       insert_pct = 50;
            default: insert_pct = 85;
         endcase
         for (k = 0; k < 24 && items_sent < ITEM_TOTAL; k++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               roll = $urandom_range(0, 63);
               if (roll == 0) dly = delay_type'($urandom);
               else if (roll < 4) dly = '0;
               else dly = delay_type'($urandom_range(1, 12));
               send_item(CMD_INSERT, dly, evt_type'($urandom));
            end else begin
               send_item(CMD_TICK, delay_type'($urandom), evt_type'($urandom));
            end
         end
      end
      req.valid <= 1'b0;

      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int stall_left;
      int open_left;
      bit squeeze_done;
      stall_left   = 0;
      open_left    = 0;
      squeeze_done = 1'b0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (squeeze_now && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp.ready <= 1'b1;
         end else if (quiet_tail || open_left > 0) begin
            rsp.ready <= 1'b1;
            if (open_left > 0) open_left--;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
            if (stall_left == 0) open_left = $urandom_range(0, 40);
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
         end
      end
   end

   // end the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- filelist.f -----
design/dtq_pkg.sv
design/dtq_req_if.sv
design/dtq_rsp_if.sv
design/dtq_cell.sv
design/dtq_ctrl.sv
design/delta_timer_queue_top.sv
tb/dtq_timer_checker.sv
tb/tb.sv
